### sv/spa_pkg.sv
// ----------------------------------------------------------------------------
// spa_pkg: shared types and constants
// Operation codes, saturation bounds and the saturated result word for the arithmetic unit.
// ----------------------------------------------------------------------------
package spa_pkg;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;

  localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic signed [31:0] value;
    logic               sat;
  } sat_t;

  function automatic sat_t sat33(input logic signed [32:0] v);
    sat_t r;
    r.sat = 1'b0;
    r.value = v[31:0];
    if (v > 33'sh0_7FFF_FFFF) begin
      r.value = SAT_MAX;
      r.sat = 1'b1;
    end else if (v < -33'sh0_8000_0000) begin
      r.value = SAT_MIN;
      r.sat = 1'b1;
    end
    return r;
  endfunction

endpackage

### sv/spa_qmul.sv
// ----------------------------------------------------------------------------
// spa_qmul: Q16.16 multiplier
// Registered signed 32x32 product, truncated toward zero by 2^16, saturated.
// ----------------------------------------------------------------------------
module spa_qmul (
  input  logic               clk,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output spa_pkg::sat_t      res
);

  logic signed [63:0] prod_r;
  logic signed [63:0] adj;
  logic signed [47:0] q;

  always_ff @(posedge clk) begin
    prod_r <= a * b;
  end

  always_comb begin
    adj = prod_r + (prod_r[63] ? 64'sd65535 : 64'sd0);
    q = adj[63:16];
    res.sat = 1'b0;
    res.value = q[31:0];
    if (q > 48'sh0000_7FFF_FFFF) begin
      res.value = spa_pkg::SAT_MAX;
      res.sat = 1'b1;
    end else if (q < -48'sh0000_8000_0000) begin
      res.value = spa_pkg::SAT_MIN;
      res.sat = 1'b1;
    end
  end

endmodule

### sv/sparse_polynomial_arith.sv
// ----------------------------------------------------------------------------
// sparse_polynomial_arith: sparse polynomial add, subtract, multiply
// Stores operand terms, then folds them into an exponent-indexed accumulator
// with one shared adder and emits touched exponents in descending order.
// ----------------------------------------------------------------------------
// A term word is stored as it is accepted. An end_of_job word starts a job
// that is not ready until its last result word is taken. Folding runs feed,
// wait and read-modify-write per term (add/subtract, A count + B count terms,
// plus a step to switch to the B terms) or per product (A count * B count,
// via a registered multiplier and a read-modify-write accumulator). The emit
// scan then walks down from entry 2^(EXPONENT_BITS+1)-1, passing untouched
// entries; a touched one goes through scan, memory read, output load and
// handshake, held by any out_tready stall, stopping after the lowest touched
// entry. With nothing touched it visits every entry, then emits one empty word.
module sparse_polynomial_arith #(
  parameter int MAX_TERMS     = 8,
  parameter int EXPONENT_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_wdata,      // operation
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,       // term_present, coefficient[32], exponent[8], pad
  input  logic        in_tuser,       // operand_select
  input  logic        in_tlast,       // end_of_job
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,      // result_coefficient[32], result_exponent[9],
                                      // result_empty, overflow_flag, pad
  output logic        out_tlast       // result_last
);

  localparam int CW = $clog2(MAX_TERMS + 1);
  localparam int IW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int AW = EXPONENT_BITS + 1;
  localparam int DEPTH = 2 ** AW;

  localparam logic [2:0] S_LOAD = 3'd0;
  localparam logic [2:0] S_FEED = 3'd1;
  localparam logic [2:0] S_WAIT = 3'd2;
  localparam logic [2:0] S_RMW  = 3'd3;
  localparam logic [2:0] S_SCAN = 3'd4;
  localparam logic [2:0] S_RD   = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;
  localparam logic [2:0] S_EMPT = 3'd7;

  logic [1:0] op_r;
  logic [2:0] st_r;
  logic [CW-1:0] a_cnt_r, b_cnt_r;
  logic [CW-1:0] i_r, j_r;
  logic sticky_r;
  logic b_phase_r;

  logic signed [31:0] a_coef [MAX_TERMS];
  logic [EXPONENT_BITS-1:0] a_exp [MAX_TERMS];
  logic signed [31:0] b_coef [MAX_TERMS];
  logic [EXPONENT_BITS-1:0] b_exp [MAX_TERMS];

  logic signed [31:0] acc_mem [DEPTH];
  logic [DEPTH-1:0] touched_r;
  logic signed [31:0] acc_rd_r;

  logic [AW-1:0] fidx_r;
  logic signed [31:0] fval_r;
  logic [AW-1:0] scan_r;
  logic found_r;

  logic signed [31:0] out_coef_r;
  logic [AW-1:0] out_exp_r;
  logic out_last_r, out_empty_r;

  logic in_present, in_sel, in_end;
  logic signed [31:0] in_coef;
  logic [EXPONENT_BITS-1:0] in_e;
  logic in_fire;

  assign in_present = in_tdata[0];
  assign in_coef = in_tdata[32:1];
  assign in_e = EXPONENT_BITS'(in_tdata[40:33]);
  assign in_sel = in_tuser;
  assign in_end = in_tlast;
  assign in_tready = (st_r == S_LOAD);
  assign in_fire = in_tvalid && in_tready;

  logic [IW-1:0] ii, jj;
  assign ii = i_r[IW-1:0];
  assign jj = j_r[IW-1:0];

  spa_pkg::sat_t mres;
  spa_qmul u_mul (.clk(clk), .a(a_coef[ii]), .b(b_coef[jj]), .res(mres));

  spa_pkg::sat_t sum_s, neg_s;
  assign sum_s = spa_pkg::sat33(33'(acc_rd_r) + 33'(fval_r));
  assign neg_s = spa_pkg::sat33(-33'(b_coef[jj]));

  logic is_mul;
  assign is_mul = (op_r == spa_pkg::OP_MUL);

  logic more_terms;
  logic [AW-1:0] scan_next_lo;
  always_comb begin
    if (is_mul)
      more_terms = (a_cnt_r != '0) && (b_cnt_r != '0);
    else
      more_terms = (a_cnt_r != '0) || (b_cnt_r != '0);
    scan_next_lo = scan_r - AW'(1);
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_present) begin
      if (!in_sel && a_cnt_r < CW'(MAX_TERMS)) begin
        a_coef[a_cnt_r[IW-1:0]] <= in_coef;
        a_exp[a_cnt_r[IW-1:0]] <= in_e;
      end
      if (in_sel && b_cnt_r < CW'(MAX_TERMS)) begin
        b_coef[b_cnt_r[IW-1:0]] <= in_coef;
        b_exp[b_cnt_r[IW-1:0]] <= in_e;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == S_RMW)
      acc_mem[fidx_r] <= touched_r[fidx_r] ? sum_s.value : fval_r;
    if (st_r == S_FEED || st_r == S_WAIT)
      acc_rd_r <= acc_mem[fidx_r];
    else if (st_r == S_RD)
      acc_rd_r <= acc_mem[scan_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r <= spa_pkg::OP_ADD;
      st_r <= S_LOAD;
      a_cnt_r <= '0;
      b_cnt_r <= '0;
      i_r <= '0;
      j_r <= '0;
      sticky_r <= 1'b0;
      b_phase_r <= 1'b0;
      touched_r <= '0;
      out_tvalid <= 1'b0;
      found_r <= 1'b0;
      scan_r <= '0;
    end else begin
      if (cfg_we) op_r <= cfg_wdata;
      unique case (st_r)
        S_LOAD: begin
          if (in_fire) begin
            if (in_present) begin
              if (!in_sel) begin
                if (a_cnt_r < CW'(MAX_TERMS)) a_cnt_r <= a_cnt_r + CW'(1);
                else sticky_r <= 1'b1;
              end else begin
                if (b_cnt_r < CW'(MAX_TERMS)) b_cnt_r <= b_cnt_r + CW'(1);
                else sticky_r <= 1'b1;
              end
            end
            if (in_end) begin
              st_r <= S_FEED;
              i_r <= '0;
              j_r <= '0;
              b_phase_r <= 1'b0;
            end
          end
        end
        S_FEED: begin
          // counts are final here; pick the next term/product
          if (!more_terms || (!is_mul && b_phase_r && j_r == b_cnt_r)) begin
            st_r <= S_SCAN;
            scan_r <= AW'(DEPTH - 1);
            found_r <= 1'b0;
          end else if (is_mul) begin
            fidx_r <= AW'(a_exp[ii]) + AW'(b_exp[jj]);
            st_r <= S_WAIT;
          end else if (!b_phase_r && i_r == a_cnt_r) begin
            b_phase_r <= 1'b1;
          end else if (!b_phase_r) begin
            fidx_r <= AW'(a_exp[ii]);
            fval_r <= a_coef[ii];
            st_r <= S_WAIT;
          end else begin
            fidx_r <= AW'(b_exp[jj]);
            if (op_r == spa_pkg::OP_SUB) begin
              fval_r <= neg_s.value;
              if (neg_s.sat) sticky_r <= 1'b1;
            end else begin
              fval_r <= b_coef[jj];
            end
            st_r <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (is_mul) begin
            fval_r <= mres.value;
            if (mres.sat) sticky_r <= 1'b1;
          end
          st_r <= S_RMW;
        end
        S_RMW: begin
          touched_r[fidx_r] <= 1'b1;
          if (touched_r[fidx_r] && sum_s.sat) sticky_r <= 1'b1;
          if (is_mul) begin
            if (j_r + CW'(1) == b_cnt_r) begin
              j_r <= '0;
              i_r <= i_r + CW'(1);
              st_r <= (i_r + CW'(1) == a_cnt_r) ? S_SCAN : S_FEED;
            end else begin
              j_r <= j_r + CW'(1);
              st_r <= S_FEED;
            end
          end else begin
            if (b_phase_r) j_r <= j_r + CW'(1);
            else i_r <= i_r + CW'(1);
            st_r <= S_FEED;
          end
          scan_r <= AW'(DEPTH - 1);
          found_r <= 1'b0;
        end
        S_SCAN: begin
          if (touched_r[scan_r]) begin
            st_r <= S_RD;
          end else if (scan_r == '0) begin
            st_r <= found_r ? S_LOAD : S_EMPT;
            if (found_r) begin
              a_cnt_r <= '0; b_cnt_r <= '0; sticky_r <= 1'b0; touched_r <= '0;
            end
          end else begin
            scan_r <= scan_next_lo;
          end
        end
        S_RD: begin
          st_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_tvalid) begin
            out_coef_r <= acc_rd_r;
            out_exp_r <= scan_r;
            out_empty_r <= 1'b0;
            out_last_r <= ((touched_r & ((DEPTH)'(1) << scan_r) - (DEPTH)'(1)) == '0);
            out_tvalid <= 1'b1;
          end else if (out_tready) begin
            out_tvalid <= 1'b0;
            found_r <= 1'b1;
            if (out_last_r) begin
              st_r <= S_LOAD;
              a_cnt_r <= '0; b_cnt_r <= '0; sticky_r <= 1'b0; touched_r <= '0;
            end else begin
              scan_r <= scan_next_lo;
              st_r <= S_SCAN;
            end
          end
        end
        S_EMPT: begin
          if (!out_tvalid) begin
            out_coef_r <= '0;
            out_exp_r <= '0;
            out_empty_r <= 1'b1;
            out_last_r <= 1'b1;
            out_tvalid <= 1'b1;
          end else if (out_tready) begin
            out_tvalid <= 1'b0;
            st_r <= S_LOAD;
            a_cnt_r <= '0; b_cnt_r <= '0; sticky_r <= 1'b0; touched_r <= '0;
          end
        end
        default: st_r <= S_LOAD;
      endcase
    end
  end

  always_comb begin
    out_tdata = '0;
    out_tdata[31:0] = out_coef_r;
    out_tdata[32 +: 9] = 9'(out_exp_r);
    out_tdata[41] = out_empty_r;
    out_tdata[42] = sticky_r;
    out_tlast = out_last_r;
  end

endmodule

### verif/tb_sparse_polynomial_arith.sv
// ----------------------------------------------------------------------------
// tb_sparse_polynomial_arith: sparse polynomial add/subtract/multiply check
// Loads operand terms, ends jobs under each operation and compares every
// result word against a behavioral model of the term fold, saturation and
// descending-exponent emit. Random source gaps and sink stalls.
// ----------------------------------------------------------------------------
module tb_sparse_polynomial_arith;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_TERMS = 8;
  localparam int ACC_DEPTH = 512;
  localparam logic [1:0] OP_SPARE = 2'd3;

  typedef struct packed {
    logic signed [31:0] coef;
    logic [8:0]         expo;
    logic               last;
    logic               empty;
    logic               ovf;
  } term_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic        out_tlast;

  sparse_polynomial_arith i_dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast), .out_tvalid(out_tvalid),
    .out_tready(out_tready), .out_tdata(out_tdata), .out_tlast(out_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("sparse_polynomial_arith test failed");
    $finish;
  end

  // model state
  logic signed [31:0] a_coef [MAX_TERMS];
  logic [7:0]         a_expo [MAX_TERMS];
  logic signed [31:0] b_coef [MAX_TERMS];
  logic [7:0]         b_expo [MAX_TERMS];
  int                 a_cnt, b_cnt;
  logic signed [31:0] acc [ACC_DEPTH];
  bit                 touched [ACC_DEPTH];
  bit                 sticky;
  logic [1:0]         op_mode;

  term_result_t expected_terms[$];
  int  errors = 0;
  bit  stall_free = 1'b0;

  function automatic logic signed [31:0] clamp(input logic signed [63:0] v);
    if (v > 64'sh7FFF_FFFF) begin
      sticky = 1'b1;
      return spa_pkg::SAT_MAX;
    end
    if (v < -64'sh8000_0000) begin
      sticky = 1'b1;
      return spa_pkg::SAT_MIN;
    end
    return v[31:0];
  endfunction

  function automatic void fold(input int e, input logic signed [31:0] c);
    if (!touched[e]) begin
      touched[e] = 1'b1;
      acc[e] = c;
    end else begin
      acc[e] = clamp(64'(acc[e]) + 64'(c));
    end
  endfunction

  function automatic void predict_job();
    logic signed [63:0] p;
    int n;
    term_result_t r;
    n = 0;
    if (op_mode == spa_pkg::OP_MUL) begin
      for (int i = 0; i < a_cnt; i++)
        for (int j = 0; j < b_cnt; j++) begin
          p = 64'(a_coef[i]) * 64'(b_coef[j]);
          fold(int'(a_expo[i]) + int'(b_expo[j]), clamp(p / 65536));
        end
    end else begin
      for (int i = 0; i < a_cnt; i++) fold(a_expo[i], a_coef[i]);
      for (int j = 0; j < b_cnt; j++)
        fold(b_expo[j], (op_mode == spa_pkg::OP_SUB) ? clamp(-64'(b_coef[j])) : b_coef[j]);
    end
    for (int e = ACC_DEPTH - 1; e >= 0; e--) begin
      if (touched[e]) begin
        r = '{coef: acc[e], expo: 9'(e), last: 1'b0, empty: 1'b0, ovf: sticky};
        expected_terms.insert(expected_terms.size(), r);
        n++;
      end
    end
    if (n == 0) begin
      r = '{coef: '0, expo: '0, last: 1'b1, empty: 1'b1, ovf: sticky};
      expected_terms.insert(expected_terms.size(), r);
    end else begin
      expected_terms[$].last = 1'b1;
    end
    a_cnt = 0;
    b_cnt = 0;
    sticky = 1'b0;
    for (int e = 0; e < ACC_DEPTH; e++) touched[e] = 1'b0;
  endfunction

  function automatic void predict_word(input bit sel, input bit present,
                                       input logic signed [31:0] c,
                                       input logic [7:0] e, input bit eoj);
    if (present) begin
      if (!sel) begin
        if (a_cnt < MAX_TERMS) begin
          a_coef[a_cnt] = c; a_expo[a_cnt] = e; a_cnt++;
        end else sticky = 1'b1;
      end else begin
        if (b_cnt < MAX_TERMS) begin
          b_coef[b_cnt] = c; b_expo[b_cnt] = e; b_cnt++;
        end else sticky = 1'b1;
      end
    end
    if (eoj) predict_job();
  endfunction

  function automatic bit idle_now();
    return !stall_free && ($urandom_range(99) < 30);
  endfunction

  task automatic send_word(input bit sel, input bit present,
                           input logic signed [31:0] c, input logic [7:0] e,
                           input bit eoj);
    if (idle_now()) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      while (idle_now()) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= sel;
    in_tlast  <= eoj;
    in_tdata  <= {7'd0, e, c, present};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_word(sel, present, c, e, eoj);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    in_tvalid <= 1'b0;
    while (expected_terms.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (40) @(posedge clk);
  endtask

  task automatic set_operation(input logic [1:0] op);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= op;
    @(posedge clk);
    cfg_we    <= 1'b0;
    op_mode = op;
  endtask

  // result checker
  always @(posedge clk) begin
    term_result_t got, want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = '{coef: out_tdata[31:0], expo: out_tdata[40:32], last: out_tlast,
                empty: out_tdata[41], ovf: out_tdata[42]};
        if (expected_terms.size() == 0) begin
          $display("%0t: unexpected result word %h", $time, got);
          errors++;
        end else begin
          want = expected_terms.pop_front();
          if (got.coef !== want.coef)
            $display("%0t: coef exp %h got %h", $time, want.coef, got.coef);
          if (got.expo !== want.expo)
            $display("%0t: expo exp %0d got %0d", $time, want.expo, got.expo);
          if (got.last !== want.last)
            $display("%0t: last exp %b got %b", $time, want.last, got.last);
          if (got.empty !== want.empty)
            $display("%0t: empty exp %b got %b", $time, want.empty, got.empty);
          if (got.ovf !== want.ovf)
            $display("%0t: ovf exp %b got %b", $time, want.ovf, got.ovf);
          if (got !== want) errors++;
        end
      end
      out_tready <= !idle_now();
    end
  end

  function automatic logic signed [31:0] rand_coef();
    case ($urandom_range(5))
      0: return spa_pkg::SAT_MAX;
      1: return spa_pkg::SAT_MIN;
      2: return 32'(int'($urandom_range(65536 * 8)) - 65536 * 4);
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed();
    set_operation(spa_pkg::OP_ADD);
    send_word(1'b0, 1'b1, 32'sd0, 8'd0, 1'b1);
    send_word(1'b0, 1'b0, 32'sd0, 8'd0, 1'b1);                // empty job
    send_word(1'b0, 1'b1, spa_pkg::SAT_MAX, 8'd255, 1'b0);
    send_word(1'b1, 1'b1, spa_pkg::SAT_MAX, 8'd255, 1'b0);   // sat add
    send_word(1'b1, 1'b1, 32'sh0001_0000, 8'd3, 1'b0);
    send_word(1'b0, 1'b0, 32'sh1234_5678, 8'd9, 1'b0);        // no-op word
    send_word(1'b0, 1'b1, -32'sh0001_0000, 8'd3, 1'b1);       // zero sum kept
    set_operation(spa_pkg::OP_SUB);
    send_word(1'b1, 1'b1, spa_pkg::SAT_MIN, 8'd1, 1'b0);     // negate min
    send_word(1'b0, 1'b1, spa_pkg::SAT_MIN, 8'd7, 1'b1);
    for (int k = 0; k < 10; k++)                             // operand full
      send_word(1'b1, 1'b1, 32'(k * 65536), 8'(k), k == 9);
    set_operation(spa_pkg::OP_MUL);
    send_word(1'b0, 1'b1, spa_pkg::SAT_MAX, 8'd255, 1'b0);
    send_word(1'b1, 1'b1, spa_pkg::SAT_MIN, 8'd255, 1'b0);
    send_word(1'b1, 1'b1, -32'sd3, 8'd0, 1'b1);               // trunc toward 0
    send_word(1'b0, 1'b1, 32'sh0002_0000, 8'd4, 1'b1);        // empty B
    set_operation(OP_SPARE);
    send_word(1'b0, 1'b1, 32'sh0001_0000, 8'd2, 1'b0);
    send_word(1'b1, 1'b1, 32'sh0002_0000, 8'd2, 1'b1);
  endtask

  task automatic test_random(input int words);
    int sent, n_a, n_b, ops;
    sent = 0;
    while (sent < words) begin
      ops = $urandom_range(3);
      set_operation(ops[1:0]);
      if ($urandom_range(3) == 0) stall_free = ~stall_free;
      n_a = (ops[1:0] == spa_pkg::OP_MUL) ? $urandom_range(4) : $urandom_range(10);
      n_b = (ops[1:0] == spa_pkg::OP_MUL) ? $urandom_range(4) : $urandom_range(10);
      for (int k = 0; k < n_a + n_b; k++) begin
        send_word(k >= n_a, $urandom_range(15) != 0, rand_coef(),
                  ($urandom_range(1) ? 8'($urandom_range(7)) : 8'($urandom)), 1'b0);
        sent++;
      end
      send_word($urandom_range(1), $urandom_range(1), rand_coef(),
                8'($urandom), 1'b1);
      sent++;
    end
    stall_free = 1'b0;
  endtask

  initial begin
    a_cnt = 0; b_cnt = 0; sticky = 1'b0; op_mode = spa_pkg::OP_ADD;
    for (int e = 0; e < ACC_DEPTH; e++) touched[e] = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(450);
    drain();
    if (errors == 0 && expected_terms.size() == 0) begin
      $display("sparse_polynomial_arith test passed");
    end else begin
      $display("sparse_polynomial_arith test failed");
    end
    $finish;
  end

endmodule
